// File: hw/rtl/vzs_pkg.sv
// Package: shared types, constants and tables for the velocity zone selector.
package vzs_pkg;

  localparam int NUM_ZONES      = 4;
  localparam int CORDIC_STEPS   = 16;
  localparam int WORDS_PER_ZONE = 6;
  localparam int TABLE_DEPTH    = NUM_ZONES * WORDS_PER_ZONE;
  localparam int TIDX_W         = $clog2(TABLE_DEPTH);
  localparam int ZIDX_W         = 2;
  localparam int CW             = 34;  // CORDIC x/y/z width
  localparam int MW             = 18;  // magnitude and heading width
  localparam int PW             = CW + 32;

  localparam logic [31:0]          GAIN_Q32 = 32'd2608131496;
  localparam logic signed [31:0]   PI_Q29   = 32'sd1686629713;
  localparam logic signed [CW-1:0] BIN_PI   = CW'(64'sd2147483648);

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    W_ANG_MIN  = 3'd0,
    W_ANG_MAX  = 3'd1,
    W_LIN_MIN  = 3'd2,
    W_LIN_MAX  = 3'd3,
    W_HEAD_BEG = 3'd4,
    W_HEAD_END = 3'd5
  } word_t;

  typedef enum logic {
    REG_HOLONOMIC  = 1'b0,
    REG_ZONE_COUNT = 1'b1
  } reg_t;

  typedef struct packed {
    logic               command;
    logic [1:0]         entry_index;
    logic [2:0]         word_select;
    logic signed [15:0] word_value;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } item_t;

  function automatic logic signed [CW-1:0] atan_bin(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
        3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
        9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
        12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
        15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
        18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
        21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      atan_bin = $signed({{(CW-32){1'b0}}, v});
    end
  endfunction

endpackage

// File: hw/rtl/velocity_zone_selector.sv
// Top level: velocity zone selector with config registers and output stage.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_ready  | command, entry_index, word_select, word_value,
//          |           |                    | vel_x, vel_y, yaw_rate
//  out_    | result    | out_valid/out_ready| found, zone_index
//  config  | APB write | psel/penable/pready| paddr, pwdata, prdata
//
// One request per cycle while out_ready does not stall the pipeline; one CORDIC
// iteration per pipeline stage plus pre-rotation, scale, round and search.
// Reset (synchronous, rst_n low) clears valid bits and holonomic mode and sets zone count to 1; bounds undefined.
// A stalled result holds every stage; write requests give no result.
module velocity_zone_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [1:0]  in_entry_index,
  input  logic [2:0]  in_word_select,
  input  logic signed [15:0] in_word_value,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [1:0]  out_zone_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vzs_pkg::*;

  logic                 en;
  item_t                in_item, p_item;
  logic                 p_valid;
  logic signed [MW-1:0] p_mag, p_head;
  logic                 s_found;
  logic [ZIDX_W-1:0]    s_idx;
  logic                 holo_r, out_valid_r, out_found_r;
  logic [2:0]           count_r;
  logic [ZIDX_W-1:0]    out_idx_r;
  reg_t                 reg_sel;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;
  assign reg_sel  = reg_t'(paddr[2]);

  assign in_item = '{command: in_command, entry_index: in_entry_index,
                     word_select: in_word_select, word_value: in_word_value,
                     vel_x: in_vel_x, vel_y: in_vel_y, yaw_rate: in_yaw_rate};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holo_r  <= 1'b0;
      count_r <= 3'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_HOLONOMIC:  holo_r  <= pwdata[0];
        REG_ZONE_COUNT: count_r <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HOLONOMIC:  prdata = {31'b0, holo_r};
      REG_ZONE_COUNT: prdata = {29'b0, count_r};
    endcase
  end

  vzs_polar u_polar (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_item(in_item),
    .out_valid(p_valid), .out_item(p_item), .out_mag(p_mag), .out_head(p_head)
  );

  vzs_zone_table u_table (
    .clk(clk), .en(en), .in_valid(p_valid), .in_item(p_item), .in_mag(p_mag),
    .in_head(p_head), .holonomic_mode(holo_r), .zone_count(count_r),
    .found(s_found), .zone_index(s_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_valid && p_item.command == CMD_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_found_r <= s_found;
      out_idx_r   <= s_idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_zone_index = out_idx_r;

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_idx_r == '0)
    else $error("zone index not zero on miss");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> 3'(out_idx_r) < count_r)
    else $error("zone index beyond zone count");

  a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    en && p_valid && p_item.command == CMD_WRITE |=> !out_valid_r)
    else $error("write request produced a result");

endmodule

// File: hw/rtl/vzs_polar.sv
// Pipelined vectoring CORDIC: speed magnitude and heading from vel_x, vel_y.
module vzs_polar (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  vzs_pkg::item_t                    in_item,
  output logic                              out_valid,
  output vzs_pkg::item_t                    out_item,
  output logic signed [vzs_pkg::MW-1:0]     out_mag,
  output logic signed [vzs_pkg::MW-1:0]     out_head
);
  import vzs_pkg::*;

  logic                 v_r  [0:CORDIC_STEPS+2];
  item_t                it_r [0:CORDIC_STEPS+2];
  logic signed [CW-1:0] x_r  [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r  [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_r  [0:CORDIC_STEPS];

  logic signed [CW-1:0] xs, ys, x0_nxt, y0_nxt, z0_nxt;
  logic [PW-1:0]        pm_r;
  logic signed [PW-1:0] ph_r;
  logic [PW:0]          mag_sum, ph_abs_sum;
  logic [PW-1:0]        ph_abs;
  logic [MW-1:0]        hr;
  logic signed [MW-1:0] mag_r, head_r;

  always_comb begin
    xs = {{(CW-30){in_item.vel_x[15]}}, in_item.vel_x, 14'b0};
    ys = {{(CW-30){in_item.vel_y[15]}}, in_item.vel_y, 14'b0};
    if (in_item.vel_x[15]) begin
      x0_nxt = -xs;
      y0_nxt = -ys;
      z0_nxt = in_item.vel_y[15] ? -BIN_PI : BIN_PI;
    end else begin
      x0_nxt = xs;
      y0_nxt = ys;
      z0_nxt = '0;
    end
  end

  // valid bits
  genvar g;
  generate
    for (g = 0; g <= CORDIC_STEPS + 2; g++) begin : g_valid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (en) begin
          v_r[g] <= (g == 0) ? in_valid : v_r[(g == 0) ? 0 : g-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      x_r[0]  <= x0_nxt;
      y_r[0]  <= y0_nxt;
      z_r[0]  <= z0_nxt;
    end
  end

  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_iter
      always_ff @(posedge clk) begin
        if (en) begin
          it_r[g+1] <= it_r[g];
          if (!y_r[g][CW-1]) begin
            x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
            y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
            z_r[g+1] <= z_r[g] + atan_bin(g);
          end else begin
            x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
            y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
            z_r[g+1] <= z_r[g] - atan_bin(g);
          end
        end
      end
    end
  endgenerate

  // gain and angle scaling
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[CORDIC_STEPS+1] <= it_r[CORDIC_STEPS];
      pm_r <= PW'(x_r[CORDIC_STEPS]) * PW'(GAIN_Q32);
      ph_r <= PW'(z_r[CORDIC_STEPS]) * PW'(PI_Q29);
    end
  end

  always_comb begin
    mag_sum    = {1'b0, pm_r} + ((PW+1)'(1) << 45);
    ph_abs     = ph_r[PW-1] ? PW'(-ph_r) : PW'(ph_r);
    ph_abs_sum = {1'b0, ph_abs} + ((PW+1)'(1) << 47);
    hr         = ph_abs_sum[48 +: MW];
  end

  // rounding
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[CORDIC_STEPS+2] <= it_r[CORDIC_STEPS+1];
      if (it_r[CORDIC_STEPS+1].vel_x == '0 && it_r[CORDIC_STEPS+1].vel_y == '0) begin
        mag_r  <= '0;
        head_r <= '0;
      end else begin
        mag_r  <= $signed(mag_sum[46 +: MW]);
        head_r <= ph_r[PW-1] ? -$signed(hr) : $signed(hr);
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS+2];
  assign out_item  = it_r[CORDIC_STEPS+2];
  assign out_mag   = mag_r;
  assign out_head  = head_r;

endmodule

// File: hw/rtl/vzs_zone_table.sv
// Zone bound table, in-order bound writes and first-match zone search.
module vzs_zone_table (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          in_valid,
  input  vzs_pkg::item_t                in_item,
  input  logic signed [vzs_pkg::MW-1:0] in_mag,
  input  logic signed [vzs_pkg::MW-1:0] in_head,
  input  logic                          holonomic_mode,
  input  logic [2:0]                    zone_count,
  output logic                          found,
  output logic [vzs_pkg::ZIDX_W-1:0]    zone_index
);
  import vzs_pkg::*;

  logic signed [15:0]     bound_r [0:TABLE_DEPTH-1];
  logic [TIDX_W-1:0]      waddr;
  logic [NUM_ZONES-1:0]   hit;
  logic signed [MW-1:0]   lin, wz, amin, amax, lmin, lmax, hs, he;
  logic                   ok;
  logic [2:0]             n;

  assign waddr = TIDX_W'(in_item.entry_index * WORDS_PER_ZONE) + TIDX_W'(in_item.word_select);

  always_ff @(posedge clk) begin
    if (en && in_valid && in_item.command == CMD_WRITE &&
        32'(in_item.entry_index) < NUM_ZONES &&
        32'(in_item.word_select) < WORDS_PER_ZONE) begin
      bound_r[waddr] <= in_item.word_value;
    end
  end

  always_comb begin
    n   = (32'(zone_count) > NUM_ZONES) ? 3'(NUM_ZONES) : zone_count;
    wz  = MW'(in_item.yaw_rate);
    lin = holonomic_mode ? in_mag : MW'(in_item.vel_x);
    hit = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      amin = MW'(bound_r[z*WORDS_PER_ZONE + W_ANG_MIN]);
      amax = MW'(bound_r[z*WORDS_PER_ZONE + W_ANG_MAX]);
      lmin = MW'(bound_r[z*WORDS_PER_ZONE + W_LIN_MIN]);
      lmax = MW'(bound_r[z*WORDS_PER_ZONE + W_LIN_MAX]);
      hs   = MW'(bound_r[z*WORDS_PER_ZONE + W_HEAD_BEG]);
      he   = MW'(bound_r[z*WORDS_PER_ZONE + W_HEAD_END]);
      ok   = wz >= amin && wz <= amax && lin >= lmin && lin <= lmax;
      if (holonomic_mode) begin
        if (hs <= he) ok = ok && in_head >= hs && in_head <= he;
        else          ok = ok && (in_head >= hs || in_head <= he);
      end
      hit[z] = ok && (z < 32'(n));
    end
    found      = 1'b0;
    zone_index = '0;
    for (int z = NUM_ZONES - 1; z >= 0; z--) begin
      if (hit[z]) begin
        found      = 1'b1;
        zone_index = ZIDX_W'(z);
      end
    end
  end

endmodule
